// File: hdl/buhr_pkg.sv
// Shared types and constants of the bounded undo/redo history.
// Used by the channel interfaces and the top level; depends on nothing.
package buhr_pkg;

	localparam int KIND_W  = 2;
	localparam int TAG_W   = 32;
	localparam int BYTES_W = 32;
	localparam int LEVEL_W = 7;

	typedef logic [KIND_W-1:0] kind_t;

	localparam kind_t KIND_RECORD = 2'd0;
	localparam kind_t KIND_UNDO   = 2'd1;
	localparam kind_t KIND_REDO   = 2'd2;
	localparam kind_t KIND_CLEAR  = 2'd3;

	typedef logic cfg_idx_t;

	localparam cfg_idx_t CFG_MAX_ENTRIES = 1'b0;
	localparam cfg_idx_t CFG_MAX_BYTES   = 1'b1;

	localparam logic [LEVEL_W-1:0] MAX_ENTRIES_RST = 7'd64;
	localparam logic [BYTES_W-1:0] MAX_BYTES_RST   = 32'hFFFF_FFFF;

endpackage

// File: hdl/buhr_ifs.sv
// Valid/ready channel interfaces: operation items in, result items out and
// configuration writes. Depends on buhr_pkg.
interface buhr_cmd_if;
	import buhr_pkg::*;
	logic               valid;
	logic               ready;
	kind_t              kind;
	logic [TAG_W-1:0]   entry_tag;
	logic [BYTES_W-1:0] entry_bytes;
	logic               preserve_flag;
	modport source (output valid, kind, entry_tag, entry_bytes, preserve_flag, input ready);
	modport sink   (input valid, kind, entry_tag, entry_bytes, preserve_flag, output ready);
endinterface

interface buhr_rsp_if;
	import buhr_pkg::*;
	logic               valid;
	logic               ready;
	logic               ok;
	logic [TAG_W-1:0]   target_tag;
	logic               target_preserve;
	logic [LEVEL_W-1:0] undo_depth;
	logic [LEVEL_W-1:0] redo_depth;
	logic               undo_top_preserve;
	logic               redo_top_preserve;
	modport source (output valid, ok, target_tag, target_preserve, undo_depth, redo_depth,
		undo_top_preserve, redo_top_preserve, input ready);
	modport sink   (input valid, ok, target_tag, target_preserve, undo_depth, redo_depth,
		undo_top_preserve, redo_top_preserve, output ready);
endinterface

interface buhr_cfg_if;
	import buhr_pkg::*;
	logic               valid;
	logic               ready;
	cfg_idx_t           index;
	logic [BYTES_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/buhr_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Holds the entries of one stack; no package dependency.
module buhr_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 65
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/bounded_undo_redo_history.sv
// Bounded undo/redo history, top level. Depends on buhr_pkg, buhr_ifs, buhr_ram.
// On the way to result valid: clear, a record refused on entry or a pop from an empty stack go
// straight to the top read; a record checks, evicts and pushes; an undo or redo first pops.
// E entries are evicted (0..DEPTH), each by a check, a head read and a subtract. One item is
// in work at a time; the next is taken once the result register is loaded and idle returns.
// Reset (arst_n low) empties both stacks and restores the limits; RAM contents are kept.
module bounded_undo_redo_history #(
	parameter int DEPTH    = 64,
	parameter int TAG_BITS = 32
) (
	input logic             clk,
	input logic             arst_n,
	buhr_cmd_if.sink        cmd,
	buhr_rsp_if.source      rsp,
	buhr_cfg_if.sink        cfg
);
	import buhr_pkg::*;

	// Stored tags are the low TW bits of the incoming tag.
	localparam int TW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;
	localparam int LW = (CW > LEVEL_W) ? CW : LEVEL_W;
	// RAM word: {flag, size, tag}.
	localparam int MW = TW + BYTES_W + 1;

	// Sequencer states.
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_POPRD = 4'd1;
	localparam logic [3:0] S_POP   = 4'd2;
	localparam logic [3:0] S_PCHK  = 4'd3;
	localparam logic [3:0] S_EVCHK = 4'd4;
	localparam logic [3:0] S_EVRD  = 4'd5;
	localparam logic [3:0] S_EVAP  = 4'd6;
	localparam logic [3:0] S_PUSH  = 4'd7;
	localparam logic [3:0] S_TOPS  = 4'd8;
	localparam logic [3:0] S_TOPW  = 4'd9;

	logic [3:0]         st_q;

	// Limit registers.
	logic [LEVEL_W-1:0] max_entries_q;
	logic [BYTES_W-1:0] max_bytes_q;

	// Item being worked on.
	logic               move_q;   // undo or redo, so a pop precedes the push
	logic               dst_q;    // stack pushed onto: 0 undo, 1 redo
	logic [TW-1:0]      tag_q;
	logic [BYTES_W-1:0] bytes_q;
	logic               pflag_q;

	// Entry popped by an undo or redo.
	logic [TW-1:0]      ttag_q;
	logic [BYTES_W-1:0] tsize_q;
	logic               tflag_q;

	logic               ok_q;
	logic [BYTES_W-1:0] room_q;

	// Stack pointers: head is the oldest entry, count the entries held,
	// total the bytes held.
	logic [AW-1:0]      uh_q, rh_q;
	logic [CW-1:0]      uc_q, rc_q;
	logic [BYTES_W-1:0] ut_q, rt_q;

	logic               rsp_valid_q;
	logic               rsp_ok_q;
	logic [TAG_W-1:0]   rsp_tag_q;
	logic               rsp_tflag_q;
	logic [LEVEL_W-1:0] rsp_ud_q, rsp_rd_q;
	logic               rsp_utop_q, rsp_rtop_q;

	// Ring addresses of each stack: the slot above the top, the top itself
	// and the slot after the head.
	logic [SW-1:0]      u_sum, r_sum, u_put, r_put;
	logic [AW-1:0]      u_put_a, r_put_a, u_top_a, r_top_a, u_head_nx, r_head_nx;

	assign u_sum   = SW'(uh_q) + SW'(uc_q);
	assign r_sum   = SW'(rh_q) + SW'(rc_q);
	assign u_put   = (u_sum >= SW'(DEPTH)) ? u_sum - SW'(DEPTH) : u_sum;
	assign r_put   = (r_sum >= SW'(DEPTH)) ? r_sum - SW'(DEPTH) : r_sum;
	assign u_put_a = u_put[AW-1:0];
	assign r_put_a = r_put[AW-1:0];
	assign u_top_a = (u_put_a == '0) ? AW'(DEPTH - 1) : u_put_a - AW'(1);
	assign r_top_a = (r_put_a == '0) ? AW'(DEPTH - 1) : r_put_a - AW'(1);
	assign u_head_nx = (uh_q == AW'(DEPTH - 1)) ? '0 : uh_q + AW'(1);
	assign r_head_nx = (rh_q == AW'(DEPTH - 1)) ? '0 : rh_q + AW'(1);

	// Entry limit, with a register value above DEPTH acting as DEPTH.
	logic [LW-1:0] me_ext;
	logic [CW-1:0] lim;

	assign me_ext = LW'(max_entries_q);
	assign lim    = (me_ext > LW'(DEPTH)) ? CW'(DEPTH) : CW'(me_ext);

	// Views of the destination stack and of the other stack.
	logic [CW-1:0]      d_count;
	logic [BYTES_W-1:0] d_total, o_total;

	assign d_count = dst_q ? rc_q : uc_q;
	assign d_total = dst_q ? rt_q : ut_q;
	assign o_total = dst_q ? ut_q : rt_q;

	// RAM ports.
	logic [MW-1:0] u_rd, r_rd, src_rd, dst_rd, wdata;
	logic          u_re, r_re, u_we, r_we;
	logic [AW-1:0] u_raddr, r_raddr, waddr;

	assign src_rd = dst_q ? u_rd : r_rd;
	assign dst_rd = dst_q ? r_rd : u_rd;

	// The pop reads the source top, the eviction loop reads the destination
	// head, and the final pass reads both tops for the status flags.
	assign u_re    = (st_q == S_POPRD && dst_q) || (st_q == S_EVRD && !dst_q) ||
		(st_q == S_TOPS);
	assign r_re    = (st_q == S_POPRD && !dst_q) || (st_q == S_EVRD && dst_q) ||
		(st_q == S_TOPS);
	assign u_raddr = (st_q == S_EVRD) ? uh_q : u_top_a;
	assign r_raddr = (st_q == S_EVRD) ? rh_q : r_top_a;

	assign u_we  = (st_q == S_PUSH) && !dst_q;
	assign r_we  = (st_q == S_PUSH) && dst_q;
	assign waddr = dst_q ? r_put_a : u_put_a;
	// A record stores its own flag; a move carries the popped entry's flag.
	assign wdata = {(move_q ? tflag_q : pflag_q), bytes_q, tag_q};

	buhr_ram #(.DEPTH(DEPTH), .WIDTH(MW)) u_undo_ram (
		.clk   (clk),
		.we    (u_we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (u_re),
		.raddr (u_raddr),
		.rdata (u_rd)
	);

	buhr_ram #(.DEPTH(DEPTH), .WIDTH(MW)) u_redo_ram (
		.clk   (clk),
		.we    (r_we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (r_re),
		.raddr (r_raddr),
		.rdata (r_rd)
	);

	// Push admission: refused outright when a limit is zero or the entry does
	// not fit beside the other stack's bytes.
	logic push_refused;
	logic evict_needed;

	assign push_refused = (lim == '0) || (max_bytes_q == '0) || (bytes_q > max_bytes_q) ||
		(o_total > max_bytes_q) || (bytes_q > max_bytes_q - o_total);
	assign evict_needed = (d_count != '0) && ((d_count >= lim) || (d_total > room_q));

	assign cmd.ready = (st_q == S_IDLE);
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= MAX_ENTRIES_RST;
			max_bytes_q   <= MAX_BYTES_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_MAX_ENTRIES: max_entries_q <= cfg.data[LEVEL_W-1:0];
				CFG_MAX_BYTES:   max_bytes_q   <= cfg.data;
				default:         max_entries_q <= max_entries_q;
			endcase
		end
	end

	// Payload registers of the item in work.
	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && cmd.valid) begin
			tag_q   <= cmd.entry_tag[TW-1:0];
			bytes_q <= cmd.entry_bytes;
			pflag_q <= cmd.preserve_flag;
		end
		if (st_q == S_POP) begin
			ttag_q  <= src_rd[TW-1:0];
			tsize_q <= src_rd[TW+BYTES_W-1:TW];
			tflag_q <= src_rd[MW-1];
		end
		if (st_q == S_PCHK) begin
			room_q <= max_bytes_q - o_total - bytes_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			move_q <= 1'b0;
			dst_q  <= 1'b0;
			ok_q   <= 1'b0;
			uh_q   <= '0;
			rh_q   <= '0;
			uc_q   <= '0;
			rc_q   <= '0;
			ut_q   <= '0;
			rt_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (cmd.valid) begin
						ok_q   <= 1'b0;
						move_q <= 1'b0;
						case (cmd.kind)
							KIND_RECORD: begin
								dst_q <= 1'b0;
								// A refused record leaves the redo stack alone.
								if (max_entries_q != '0 && max_bytes_q != '0 &&
									cmd.entry_bytes <= max_bytes_q) begin
									rc_q <= '0;
									rt_q <= '0;
									st_q <= S_PCHK;
								end else begin
									st_q <= S_TOPS;
								end
							end
							KIND_UNDO: begin
								dst_q  <= 1'b1;
								move_q <= 1'b1;
								st_q   <= (uc_q != '0) ? S_POPRD : S_TOPS;
							end
							KIND_REDO: begin
								dst_q  <= 1'b0;
								move_q <= 1'b1;
								st_q   <= (rc_q != '0) ? S_POPRD : S_TOPS;
							end
							default: begin
								uc_q <= '0;
								ut_q <= '0;
								rc_q <= '0;
								rt_q <= '0;
								ok_q <= 1'b1;
								st_q <= S_TOPS;
							end
						endcase
					end
				end
				S_POPRD: begin
					st_q <= S_POP;
				end
				S_POP: begin
					// Take the top off the source stack.
					if (dst_q) begin
						uc_q <= uc_q - CW'(1);
						ut_q <= ut_q - src_rd[TW+BYTES_W-1:TW];
					end else begin
						rc_q <= rc_q - CW'(1);
						rt_q <= rt_q - src_rd[TW+BYTES_W-1:TW];
					end
					st_q <= S_PCHK;
				end
				S_PCHK: begin
					if (push_refused) begin
						// Put the popped entry back; its RAM slot is untouched.
						if (move_q) begin
							if (dst_q) begin
								uc_q <= uc_q + CW'(1);
								ut_q <= ut_q + tsize_q;
							end else begin
								rc_q <= rc_q + CW'(1);
								rt_q <= rt_q + tsize_q;
							end
						end
						st_q <= S_TOPS;
					end else begin
						st_q <= S_EVCHK;
					end
				end
				S_EVCHK: begin
					if (evict_needed) begin
						st_q <= S_EVRD;
					end else if (d_total > room_q) begin
						if (move_q) begin
							if (dst_q) begin
								uc_q <= uc_q + CW'(1);
								ut_q <= ut_q + tsize_q;
							end else begin
								rc_q <= rc_q + CW'(1);
								rt_q <= rt_q + tsize_q;
							end
						end
						st_q <= S_TOPS;
					end else begin
						st_q <= S_PUSH;
					end
				end
				S_EVRD: begin
					st_q <= S_EVAP;
				end
				S_EVAP: begin
					// Drop the oldest entry of the destination stack.
					if (dst_q) begin
						rt_q <= rt_q - dst_rd[TW+BYTES_W-1:TW];
						rh_q <= r_head_nx;
						rc_q <= rc_q - CW'(1);
					end else begin
						ut_q <= ut_q - dst_rd[TW+BYTES_W-1:TW];
						uh_q <= u_head_nx;
						uc_q <= uc_q - CW'(1);
					end
					st_q <= S_EVCHK;
				end
				S_PUSH: begin
					if (dst_q) begin
						rc_q <= rc_q + CW'(1);
						rt_q <= rt_q + bytes_q;
					end else begin
						uc_q <= uc_q + CW'(1);
						ut_q <= ut_q + bytes_q;
					end
					ok_q <= 1'b1;
					st_q <= S_TOPS;
				end
				S_TOPS: begin
					st_q <= S_TOPW;
				end
				S_TOPW: begin
					// Top flags are in the RAM read registers; wait for a free
					// result register.
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						st_q        <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result payload, loaded as the result register is filled.
	always_ff @(posedge clk) begin
		if (st_q == S_TOPW && (!rsp_valid_q || rsp.ready)) begin
			rsp_ok_q    <= ok_q;
			rsp_tag_q   <= (ok_q && move_q) ? TAG_W'(ttag_q) : '0;
			rsp_tflag_q <= ok_q && move_q && tflag_q;
			rsp_ud_q    <= LEVEL_W'(uc_q);
			rsp_rd_q    <= LEVEL_W'(rc_q);
			rsp_utop_q  <= (uc_q != '0) && u_rd[MW-1];
			rsp_rtop_q  <= (rc_q != '0) && r_rd[MW-1];
		end
	end

	assign rsp.valid             = rsp_valid_q;
	assign rsp.ok                = rsp_ok_q;
	assign rsp.target_tag        = rsp_tag_q;
	assign rsp.target_preserve   = rsp_tflag_q;
	assign rsp.undo_depth        = rsp_ud_q;
	assign rsp.redo_depth        = rsp_rd_q;
	assign rsp.undo_top_preserve = rsp_utop_q;
	assign rsp.redo_top_preserve = rsp_rtop_q;

endmodule
